/* sv/afi_b1_pkg.sv */
// Shared types, constants and the arccosine table builder for the AFI B1 map.
`timescale 1ns / 1ps

package afi_b1_pkg;

  // Sizing
  localparam int SAMPLE_BITS     = 16;
  localparam int ACOS_TABLE_BITS = 10;
  localparam int FIELD_W         = 16;
  localparam int ANGLE_W         = 16;
  localparam int B1_W            = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int FRAC_W          = 16;

  localparam int ACOS_ENTRIES = (1 << ACOS_TABLE_BITS) + 1;
  localparam int ACOS_IDX_W   = ACOS_TABLE_BITS + 1;
  localparam int DIV_STEPS    = ACOS_TABLE_BITS + FRAC_W;
  localparam int POS_W        = DIV_STEPS + 1;
  localparam int PROD_W       = FIELD_W + CFG_DATA_W;
  localparam int NUM_W        = PROD_W + 2;
  localparam int REM_W        = NUM_W + 1;
  localparam int B1_NUM_W     = ANGLE_W + 12;

  localparam logic [FIELD_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  localparam logic [CFG_DATA_W-1:0] TR_RATIO_RESET = 16'd1280;
  localparam logic [CFG_DATA_W-1:0] NOMINAL_RESET  = 16'd15360;
  localparam logic [B1_W-1:0]       B1_UNITY       = 16'd4096;
  localparam logic [B1_W-1:0]       B1_MAX         = 16'hFFFF;
  localparam logic [ANGLE_W-1:0]    HALF_TURN      = 16'd46080;

  localparam longint HALF_TURN_L    = 46080;
  localparam longint QUARTER_TURN_L = 23040;
  localparam longint Q30_ONE        = 64'sd1 << 30;
  localparam longint PI_Q30         = 64'sd3373259426;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TR_RATIO     = 1'b0,
    REG_NOMINAL_FLIP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] first_sample;
    logic [FIELD_W-1:0] second_sample;
    logic               in_mask;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] flip_deg;
    logic [B1_W-1:0]    b1_ratio;
    logic               invalid;
  } result_t;

  // Per-beat flags that ride along with the datapath
  typedef struct packed {
    logic masked;
    logic no_signal;
  } side_t;

  typedef logic [ANGLE_W-1:0] acos_rom_t [ACOS_ENTRIES];

  // Cosine in Q30 of a Q8.8 degree angle in the first quadrant
  function automatic longint cos_quarter(longint a);
    longint theta;
    longint th2;
    longint term;
    longint sum;
    theta = a * PI_Q30 / HALF_TURN_L;
    th2   = (theta * theta) >>> 30;
    term  = Q30_ONE;
    sum   = Q30_ONE;
    // Nine Taylor terms, each divided by (2k-1)(2k)
    term = ((term * th2) >>> 30) / 2;
    sum  = sum - term;
    term = ((term * th2) >>> 30) / 12;
    sum  = sum + term;
    term = ((term * th2) >>> 30) / 30;
    sum  = sum - term;
    term = ((term * th2) >>> 30) / 56;
    sum  = sum + term;
    term = ((term * th2) >>> 30) / 90;
    sum  = sum - term;
    term = ((term * th2) >>> 30) / 132;
    sum  = sum + term;
    term = ((term * th2) >>> 30) / 182;
    sum  = sum - term;
    term = ((term * th2) >>> 30) / 240;
    sum  = sum + term;
    term = ((term * th2) >>> 30) / 306;
    sum  = sum - term;
    return sum;
  endfunction

  function automatic longint cos_q88(longint a);
    if (a > QUARTER_TURN_L) return -cos_quarter(HALF_TURN_L - a);
    return cos_quarter(a);
  endfunction

  // Largest angle whose cosine is at least each table point
  function automatic acos_rom_t acos_table();
    acos_rom_t t;
    longint    x;
    longint    lo;
    longint    hi;
    longint    mid;
    for (int i = 0; i < ACOS_ENTRIES; i++) begin
      x  = -Q30_ONE + longint'(i) * (64'sd1 <<< (31 - ACOS_TABLE_BITS));
      lo = 0;
      hi = HALF_TURN_L;
      while (lo < hi) begin
        mid = (lo + hi + 1) >>> 1;
        if (cos_q88(mid) >= x) lo = mid;
        else                   hi = mid - 1;
      end
      t[i] = ANGLE_W'(lo);
    end
    return t;
  endfunction

endpackage

/* sv/afi_b1_front.sv */
// Front end: ratio products, fraction terms, sign fix and range classification.
`timescale 1ns / 1ps

module afi_b1_front import afi_b1_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  side_t                   in_side,
  input  logic [FIELD_W-1:0]      t1,
  input  logic [FIELD_W-1:0]      t2,
  input  logic [CFG_DATA_W-1:0]   tr_ratio,
  output logic                    out_valid,
  output side_t                   out_side,
  output logic [NUM_W-1:0]        dividend,
  output logic [NUM_W-1:0]        divisor,
  output logic                    force_full,
  output logic                    force_zero
);

  logic [3:0]               valid;
  side_t                    side [4];

  logic [PROD_W-1:0]        p1n;
  logic [PROD_W-1:0]        p2n;
  logic [FIELD_W-1:0]       t1_d;
  logic [FIELD_W-1:0]       t2_d;
  logic signed [NUM_W-1:0]  num;
  logic signed [NUM_W-1:0]  den;
  logic signed [NUM_W-1:0]  num_n;
  logic signed [NUM_W-1:0]  den_n;

  // Advance valid bits and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], in_valid};
    end
    side[0] <= in_side;
    side[1] <= side[0];
    side[2] <= side[1];
    side[3] <= side[2];
  end

  // Stage 1: products with the TR ratio
  always_ff @(posedge clk) begin
    p2n  <= PROD_W'(t2) * PROD_W'(tr_ratio);
    p1n  <= PROD_W'(t1) * PROD_W'(tr_ratio);
    t1_d <= t1;
    t2_d <= t2;
  end

  // Stage 2: numerator and denominator of the fraction
  always_ff @(posedge clk) begin
    num <= $signed(NUM_W'(p2n)) - $signed(NUM_W'({t1_d, 8'h00}));
    den <= $signed(NUM_W'(p1n)) - $signed(NUM_W'({t2_d, 8'h00}));
  end

  // Stage 3: make the denominator nonnegative
  always_ff @(posedge clk) begin
    if (den < 0) begin
      num_n <= -num;
      den_n <= -den;
    end else begin
      num_n <= num;
      den_n <= den;
    end
  end

  // Stage 4: clamp outside [-1,1], else set up (num+den)/(2*den)
  always_ff @(posedge clk) begin
    if (den_n == '0) begin
      force_full <= (num_n >= 0);
      force_zero <= (num_n < 0);
    end else begin
      force_full <= (num_n >= den_n);
      force_zero <= (num_n <= -den_n);
    end
    dividend <= NUM_W'(num_n + den_n);
    divisor  <= NUM_W'(den_n <<< 1);
  end

  assign out_valid = valid[3];
  assign out_side  = side[3];

endmodule

/* sv/afi_b1_pos_div.sv */
// Pipelined restoring divider: table position, one quotient bit per stage.
`timescale 1ns / 1ps

module afi_b1_pos_div import afi_b1_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  side_t            in_side,
  input  logic [NUM_W-1:0] dividend,
  input  logic [NUM_W-1:0] divisor,
  input  logic             force_full,
  input  logic             force_zero,
  output logic             out_valid,
  output side_t            out_side,
  output logic [POS_W-1:0] pos
);

  logic                 valid [DIV_STEPS+1];
  side_t                side  [DIV_STEPS+1];
  logic [NUM_W-1:0]     rem   [DIV_STEPS+1];
  logic [NUM_W-1:0]     dvs   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo   [DIV_STEPS+1];
  logic                 ffull [DIV_STEPS+1];
  logic                 fzero [DIV_STEPS+1];

  assign valid[0] = in_valid;
  assign side[0]  = in_side;
  assign rem[0]   = dividend;
  assign dvs[0]   = divisor;
  assign quo[0]   = '0;
  assign ffull[0] = force_full;
  assign fzero[0] = force_zero;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [REM_W-1:0] shifted;
    logic             ge;

    // Shift in a zero and try to subtract
    assign shifted = {rem[k], 1'b0};
    assign ge      = (shifted >= REM_W'(dvs[k]));

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= valid[k];
      end
      side[k+1]  <= side[k];
      dvs[k+1]   <= dvs[k];
      ffull[k+1] <= ffull[k];
      fzero[k+1] <= fzero[k];
      quo[k+1]   <= {quo[k][DIV_STEPS-2:0], ge};
      rem[k+1]   <= ge ? NUM_W'(shifted - REM_W'(dvs[k])) : NUM_W'(shifted);
    end
  end

  // Pick clamped ends over the quotient
  always_comb begin
    if (ffull[DIV_STEPS])      pos = POS_W'(1) << DIV_STEPS;
    else if (fzero[DIV_STEPS]) pos = '0;
    else                       pos = {1'b0, quo[DIV_STEPS]};
  end

  assign out_valid = valid[DIV_STEPS];
  assign out_side  = side[DIV_STEPS];

endmodule

/* sv/afi_b1_acos.sv */
// Arccosine lookup with linear interpolation from a two-bank table.
`timescale 1ns / 1ps

module afi_b1_acos import afi_b1_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [POS_W-1:0]   pos,
  output logic               out_valid,
  output side_t              out_side,
  output logic [ANGLE_W-1:0] flip
);

  localparam acos_rom_t ACOS_ROM = acos_table();

  logic [2:0]                  valid;
  side_t                       side [3];

  logic [ACOS_IDX_W-1:0]       idx;
  logic                        sat;
  logic [ACOS_TABLE_BITS-1:0]  even_addr;
  logic [ACOS_TABLE_BITS-2:0]  odd_addr;

  logic [ANGLE_W-1:0]          even_q;
  logic [ANGLE_W-1:0]          odd_q;
  logic                        odd_sel;
  logic                        sat_q;
  logic [FRAC_W-1:0]           frac_q;

  logic [ANGLE_W-1:0]          a0;
  logic [ANGLE_W-1:0]          a1;
  logic signed [ANGLE_W:0]     diff;
  logic [ANGLE_W-1:0]          a0_q;
  logic signed [2*ANGLE_W+1:0] prod_q;
  logic signed [2*ANGLE_W+2:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], in_valid};
    end
    side[0] <= in_side;
    side[1] <= side[0];
    side[2] <= side[1];
  end

  // Even bank holds entries 2j, odd bank 2j+1; idx and idx+1 hit one each,
  // and past the end the even bank serves the last entry
  assign idx       = pos[POS_W-1:FRAC_W];
  assign sat       = idx[ACOS_TABLE_BITS];
  assign even_addr = ACOS_TABLE_BITS'((idx + ACOS_IDX_W'(1)) >> 1);
  assign odd_addr  = idx[ACOS_TABLE_BITS-1:1];

  // Stage 1: registered table reads
  always_ff @(posedge clk) begin
    even_q  <= ACOS_ROM[{even_addr, 1'b0}];
    odd_q   <= ACOS_ROM[{1'b0, odd_addr, 1'b1}];
    odd_sel <= idx[0];
    sat_q   <= sat;
    frac_q  <= pos[FRAC_W-1:0];
  end

  // Stage 2: slope times fraction; past the end the last entry stands alone
  always_comb begin
    if (sat_q) begin
      a0 = even_q;
      a1 = even_q;
    end else if (odd_sel) begin
      a0 = odd_q;
      a1 = even_q;
    end else begin
      a0 = even_q;
      a1 = odd_q;
    end
    diff = $signed({1'b0, a1}) - $signed({1'b0, a0});
  end

  always_ff @(posedge clk) begin
    a0_q   <= a0;
    prod_q <= (2*ANGLE_W+2)'(diff * $signed({1'b0, frac_q}));
  end

  // Stage 3: add base and round half up
  assign acc = $signed({3'b000, a0_q, 16'h0000}) + (2*ANGLE_W+3)'(prod_q)
             + $signed((2*ANGLE_W+3)'(32768));

  always_ff @(posedge clk) begin
    flip <= acc[FRAC_W +: ANGLE_W];
  end

  assign out_valid = valid[2];
  assign out_side  = side[2];

endmodule

/* sv/afi_b1_ratio_div.sv */
// B1 ratio: rounded flip/nominal in Q4.12 through a pipelined divider.
`timescale 1ns / 1ps

module afi_b1_ratio_div import afi_b1_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  side_t                 in_side,
  input  logic [ANGLE_W-1:0]    flip,
  input  logic [CFG_DATA_W-1:0] nominal,
  output logic                  out_valid,
  output side_t                 out_side,
  output logic [ANGLE_W-1:0]    flip_out,
  output logic [B1_W-1:0]       b1
);

  logic [B1_NUM_W-1:0]   numer;
  logic                  sat_now;

  logic                  valid [B1_W+1];
  side_t                 side  [B1_W+1];
  logic [CFG_DATA_W-1:0] rem   [B1_W+1];
  logic [B1_W-1:0]       low   [B1_W+1];
  logic [B1_W-1:0]       quo   [B1_W+1];
  logic                  sat   [B1_W+1];
  logic [ANGLE_W-1:0]    fl    [B1_W+1];

  // Prep: scaled angle plus half the divisor, saturate when quotient overflows
  assign numer   = {flip, 12'h000} + B1_NUM_W'(nominal >> 1);
  assign sat_now = ((CFG_DATA_W+B1_W)'(numer) >= {nominal, 16'h0000});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
    side[0] <= in_side;
    rem[0]  <= CFG_DATA_W'(numer[B1_NUM_W-1:B1_W]);
    low[0]  <= numer[B1_W-1:0];
    quo[0]  <= '0;
    sat[0]  <= sat_now;
    fl[0]   <= flip;
  end

  for (genvar k = 0; k < B1_W; k++) begin : g_step
    logic [CFG_DATA_W:0] shifted;
    logic                ge;

    // Bring down the next numerator bit
    assign shifted = {rem[k], low[k][B1_W-1]};
    assign ge      = (shifted >= {1'b0, nominal});

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= valid[k];
      end
      side[k+1] <= side[k];
      low[k+1]  <= {low[k][B1_W-2:0], 1'b0};
      quo[k+1]  <= {quo[k][B1_W-2:0], ge};
      sat[k+1]  <= sat[k];
      fl[k+1]   <= fl[k];
      rem[k+1]  <= ge ? CFG_DATA_W'(shifted - {1'b0, nominal}) : CFG_DATA_W'(shifted);
    end
  end

  assign out_valid = valid[B1_W];
  assign out_side  = side[B1_W];
  assign flip_out  = fl[B1_W];
  assign b1        = sat[B1_W] ? B1_MAX : quo[B1_W];

endmodule

/* sv/afi_flip_angle_b1_map.sv */
// Top level of the AFI flip angle and B1 map pipeline.
`timescale 1ns / 1ps

// Takes one voxel per clock and never stalls: busy stays low, so start may be
// held high every cycle. Each voxel's result is shown on result for the one
// cycle that done is high, in the order taken. The path runs through the input
// register, the front end, the 26-stage divider that finds the table position,
// the table read and interpolation, the 16-stage divider for the B1 ratio and
// the output register. Write tr_ratio and nominal_flip_deg only while no voxel
// is in flight; they are read directly by the pipeline.
module afi_flip_angle_b1_map import afi_b1_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] tr_ratio;
  logic [CFG_DATA_W-1:0] nominal_flip_deg;

  logic               s0_valid;
  side_t              s0_side;
  logic [FIELD_W-1:0] s0_t1;
  logic [FIELD_W-1:0] s0_t2;

  logic               fr_valid;
  side_t              fr_side;
  logic [NUM_W-1:0]   fr_dividend;
  logic [NUM_W-1:0]   fr_divisor;
  logic               fr_full;
  logic               fr_zero;

  logic               pd_valid;
  side_t              pd_side;
  logic [POS_W-1:0]   pd_pos;

  logic               ac_valid;
  side_t              ac_side;
  logic [ANGLE_W-1:0] ac_flip;

  logic               rd_valid;
  side_t              rd_side;
  logic [ANGLE_W-1:0] rd_flip;
  logic [B1_W-1:0]    rd_b1;

  result_t            result_next;

  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tr_ratio         <= TR_RATIO_RESET;
      nominal_flip_deg <= NOMINAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TR_RATIO:     tr_ratio         <= cfg_data;
        REG_NOMINAL_FLIP: nominal_flip_deg <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_side.masked    <= !in_item.in_mask;
    s0_side.no_signal <= ((in_item.first_sample & SAMPLE_MASK) == '0);
    s0_t1             <= in_item.first_sample & SAMPLE_MASK;
    s0_t2             <= in_item.second_sample & SAMPLE_MASK;
  end

  afi_b1_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s0_valid),
    .in_side    (s0_side),
    .t1         (s0_t1),
    .t2         (s0_t2),
    .tr_ratio   (tr_ratio),
    .out_valid  (fr_valid),
    .out_side   (fr_side),
    .dividend   (fr_dividend),
    .divisor    (fr_divisor),
    .force_full (fr_full),
    .force_zero (fr_zero)
  );

  afi_b1_pos_div u_pos_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fr_valid),
    .in_side    (fr_side),
    .dividend   (fr_dividend),
    .divisor    (fr_divisor),
    .force_full (fr_full),
    .force_zero (fr_zero),
    .out_valid  (pd_valid),
    .out_side   (pd_side),
    .pos        (pd_pos)
  );

  afi_b1_acos u_acos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pd_valid),
    .in_side   (pd_side),
    .pos       (pd_pos),
    .out_valid (ac_valid),
    .out_side  (ac_side),
    .flip      (ac_flip)
  );

  afi_b1_ratio_div u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ac_valid),
    .in_side   (ac_side),
    .flip      (ac_flip),
    .nominal   (nominal_flip_deg),
    .out_valid (rd_valid),
    .out_side  (rd_side),
    .flip_out  (rd_flip),
    .b1        (rd_b1)
  );

  // Mask wins over a missing first sample
  always_comb begin
    if (rd_side.masked) begin
      result_next.flip_deg = '0;
      result_next.b1_ratio = B1_UNITY;
      result_next.invalid  = 1'b0;
    end else if (rd_side.no_signal) begin
      result_next.flip_deg = '0;
      result_next.b1_ratio = '0;
      result_next.invalid  = 1'b1;
    end else begin
      result_next.flip_deg = rd_flip;
      result_next.b1_ratio = rd_b1;
      result_next.invalid  = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd_valid;
    end
    result <= result_next;
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.invalid) |-> (result.flip_deg == '0 && result.b1_ratio == '0))
    else $error("invalid beat carries nonzero results");

  a_flip_range: assert property (@(posedge clk) disable iff (rst)
    (done && !result.invalid) |-> (result.flip_deg <= HALF_TURN))
    else $error("flip angle beyond half turn");

  a_pipe_drain: assert property (@(posedge clk) disable iff (rst)
    rd_valid |=> done)
    else $error("result beat lost at output register");

endmodule
